// ===== sv/incremental_pid_heater_top_defines.svh =====
// Assertion macros used by the heater controller top level.
// Every check is clocked on clk and switched off while rst_n is low.
`ifndef INCREMENTAL_PID_HEATER_TOP_DEFINES_SVH
`define INCREMENTAL_PID_HEATER_TOP_DEFINES_SVH

// When pre holds in a cycle, post must hold in the same cycle.
`define IPH_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// When pre holds in a cycle, post must hold in the following cycle.
`define IPH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/ipid_pkg.sv =====
`default_nettype none

package ipid_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned GainW = 8;
  localparam int unsigned CfgIdxW = 3;

  // Branch codes carried in the result item.
  localparam logic [1:0] BR_OFF  = 2'd0;
  localparam logic [1:0] BR_FULL = 2'd1;
  localparam logic [1:0] BR_CALC = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_OUTPUT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BAND       = 3'd4;

  // Reset values of the registers that do not reset to zero.
  localparam logic [DataW-1:0] MAX_OUTPUT_RST = 16'd200;
  localparam logic [DataW-1:0] BAND_RST       = 16'd100;

  typedef struct packed {
    logic [DataW-1:0] setpoint;
    logic [DataW-1:0] measured;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] drive;
    logic [1:0]       branch;
  } out_item_t;

  typedef struct packed {
    logic [GainW-1:0] prop_gain;
    logic [GainW-1:0] integ_gain;
    logic [GainW-1:0] deriv_gain;
    logic [DataW-1:0] max_output;
    logic [DataW-1:0] full_drive_band;
  } cfg_t;

  // Outcome of one item as seen by the control logic of the top level.
  typedef struct packed {
    out_item_t        item;
    logic             hist_push;
    logic [DataW-1:0] err;
  } calc_res_t;

endpackage

`default_nettype wire

// ===== sv/ipid_calc.sv =====
`default_nettype none

// Combinational step of the controller: branch decision, incremental PID sum
// and clamp for one item against the current stored state.
module ipid_calc
  import ipid_pkg::*;
(
  input  in_item_t         item,
  input  cfg_t             cfg,
  input  logic [DataW-1:0] drive_lvl,
  input  logic [DataW-1:0] err_prev0,
  input  logic [DataW-1:0] err_prev1,
  output calc_res_t        res
);

  logic [DataW-1:0]   err;
  logic               is_off;
  logic               is_full;
  logic signed [8:0]  kp_s;
  logic signed [8:0]  ki_s;
  logic signed [8:0]  kd_s;
  logic signed [16:0] e0_s;
  logic signed [16:0] d1;
  logic signed [18:0] d2;
  logic signed [25:0] p_term;
  logic signed [25:0] i_term;
  logic signed [27:0] d_term;
  logic signed [30:0] sum;
  logic signed [30:0] max_s;
  logic [DataW-1:0]   calc_drive;

  assign err     = item.setpoint - item.measured;
  assign is_off  = (item.setpoint <= item.measured);
  assign is_full = (err > cfg.full_drive_band);

  // After the shift the history is err, err_prev0, err_prev1 (newest first).
  assign kp_s = $signed({1'b0, cfg.prop_gain});
  assign ki_s = $signed({1'b0, cfg.integ_gain});
  assign kd_s = $signed({1'b0, cfg.deriv_gain});
  assign e0_s = $signed({1'b0, err});
  assign d1   = $signed({1'b0, err}) - $signed({1'b0, err_prev0});
  assign d2   = $signed({3'b000, err}) - $signed({2'b00, err_prev0, 1'b0})
              + $signed({3'b000, err_prev1});

  assign p_term = 26'(kp_s) * 26'(d1);
  assign i_term = 26'(ki_s) * 26'(e0_s);
  assign d_term = 28'(kd_s) * 28'(d2);

  assign sum   = $signed({15'd0, drive_lvl}) + 31'(p_term) + 31'(i_term) + 31'(d_term);
  assign max_s = $signed({15'd0, cfg.max_output});

  always_comb begin
    if (sum <= 31'sd0) begin
      calc_drive = '0;
    end else if (sum < max_s) begin
      calc_drive = sum[DataW-1:0];
    end else begin
      calc_drive = cfg.max_output;
    end
  end

  always_comb begin
    res.err = err;
    priority if (is_off) begin
      res.item.drive  = '0;
      res.item.branch = BR_OFF;
      res.hist_push   = 1'b0;
    end else if (is_full) begin
      res.item.drive  = cfg.max_output;
      res.item.branch = BR_FULL;
      res.hist_push   = 1'b0;
    end else begin
      res.item.drive  = calc_drive;
      res.item.branch = BR_CALC;
      res.hist_push   = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/incremental_pid_heater_top.sv =====
`default_nettype none
`include "incremental_pid_heater_top_defines.svh"

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_item_t  (setpoint, measured)
// out_      output     out_valid / out_stall out_item_t (drive, branch)
// cfg_      input      cfg_valid / cfg_ready cfg_index (3 bits), cfg_data (16 bits)
//
// Every item passes from acceptance through the input register, then
// through the PID datapath into the result register.
// One item per cycle is sustained unless out_stall holds; the shared error
// history and stored drive update on the edge that loads the result register.
// Reset is synchronous and active low; it clears gains, restores the default
// clamp and band, and clears the error history and stored drive.
// A stall on the result side holds the result and, once the input register is
// also full, raises in_stall in the same cycle.
module incremental_pid_heater_top
  import ipid_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,

  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data
);

  // Configuration registers. Writes are always accepted; an index beyond the
  // register list is dropped.
  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Input register stage.
  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_item_t s1_item_r;

  // Result register stage.
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;

  // Controller state: stored drive and the two older error samples. The
  // oldest sample of the three-deep history is never read again after a
  // shift, so only two entries are kept.
  logic [DataW-1:0] drive_lvl_r;
  logic [DataW-1:0] drive_lvl_nxt;
  logic [DataW-1:0] err0_r;
  logic [DataW-1:0] err0_nxt;
  logic [DataW-1:0] err1_r;
  logic [DataW-1:0] err1_nxt;

  logic      in_accept;
  logic      advance;
  calc_res_t calc_res;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  cfg_nxt.prop_gain       = cfg_data[GainW-1:0];
        REG_INTEG_GAIN: cfg_nxt.integ_gain      = cfg_data[GainW-1:0];
        REG_DERIV_GAIN: cfg_nxt.deriv_gain      = cfg_data[GainW-1:0];
        REG_MAX_OUTPUT: cfg_nxt.max_output      = cfg_data;
        REG_BAND:       cfg_nxt.full_drive_band = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  // The item in the input register moves on whenever the result register is
  // empty or its result is being taken in this cycle.
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  ipid_calc u_calc (
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .drive_lvl (drive_lvl_r),
    .err_prev0 (err0_r),
    .err_prev1 (err1_r),
    .res       (calc_res)
  );

  always_comb begin
    s1_valid_nxt  = in_accept || (s1_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
    drive_lvl_nxt = drive_lvl_r;
    err0_nxt      = err0_r;
    err1_nxt      = err1_r;
    if (advance) begin
      drive_lvl_nxt = calc_res.item.drive;
      if (calc_res.hist_push) begin
        err0_nxt = calc_res.err;
        err1_nxt = err0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain       <= '0;
      cfg_r.integ_gain      <= '0;
      cfg_r.deriv_gain      <= '0;
      cfg_r.max_output      <= MAX_OUTPUT_RST;
      cfg_r.full_drive_band <= BAND_RST;
      s1_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
      drive_lvl_r           <= '0;
      err0_r                <= '0;
      err1_r                <= '0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      drive_lvl_r <= drive_lvl_nxt;
      err0_r      <= err0_nxt;
      err1_r      <= err1_nxt;
    end
  end

  // Payload registers load only on a transfer and need no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= calc_res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // An accepted item must occupy the input register at the next edge.
  `IPH_ASSERT_NEXT(a_accept_fills_s1, in_accept, s1_valid_r, "accepted item lost")

  // The delivered drive always matches the stored drive right after a step.
  `IPH_ASSERT_NEXT(a_result_tracks_state, advance,
                   out_valid_r && (out_item_r.drive == drive_lvl_r),
                   "result drive differs from stored drive")

  // The off branch never reports a nonzero drive.
  `IPH_ASSERT_SAME(a_off_is_zero, advance && (calc_res.item.branch == BR_OFF),
                   calc_res.item.drive == '0, "off branch with nonzero drive")

  // The error history moves only when a computed-path item advances.
  `IPH_ASSERT_NEXT(a_hist_stable, rst_n && !(advance && calc_res.hist_push),
                   $stable(err0_r) && $stable(err1_r),
                   "error history changed without a computed step")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
module testbench
  import ipid_pkg::*;
;

  // Run length. The limit is far above the slowest correct run, which is
  // roughly a thousand items.
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 118;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 3;
  localparam int FULL_SCALE      = (1 << DataW) - 1;
  localparam int GAIN_TOP        = (1 << GainW) - 1;

  // Tracks the heater controller: it keeps its own copy of the gains, the
  // clamp, the band, the error history and the stored drive, and it queues
  // the drive and branch that each accepted sample must produce.
  class heater_drive_tracker;
    logic [GainW-1:0] kp, ki, kd;
    logic [DataW-1:0] max_out, band;
    logic [DataW-1:0] err_hist [3];
    logic [DataW-1:0] drive_level;
    out_item_t        drive_due_q [$];
    int               mismatches, samples, checked;
    int               branch_count [3];

    function new();
      kp = '0;
      ki = '0;
      kd = '0;
      max_out = MAX_OUTPUT_RST;
      band = BAND_RST;
      foreach (err_hist[i]) err_hist[i] = '0;
      drive_level = '0;
      mismatches = 0;
      samples = 0;
      checked = 0;
      foreach (branch_count[i]) branch_count[i] = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
      case (idx)
        REG_PROP_GAIN:  kp = data[GainW-1:0];
        REG_INTEG_GAIN: ki = data[GainW-1:0];
        REG_DERIV_GAIN: kd = data[GainW-1:0];
        REG_MAX_OUTPUT: max_out = data;
        REG_BAND:       band = data;
        default: ;
      endcase
    endfunction

    function void note_sample(in_item_t s);
      longint    e0, e1, e2, acc;
      out_item_t due;
      if (s.setpoint <= s.measured) begin
        drive_level = '0;
        due.branch = BR_OFF;
      end else if (s.setpoint - s.measured > band) begin
        drive_level = max_out;
        due.branch = BR_FULL;
      end else begin
        err_hist[2] = err_hist[1];
        err_hist[1] = err_hist[0];
        err_hist[0] = s.setpoint - s.measured;
        e0 = longint'(err_hist[0]);
        e1 = longint'(err_hist[1]);
        e2 = longint'(err_hist[2]);
        acc = longint'(drive_level)
            + longint'(kp) * (e0 - e1)
            + longint'(ki) * e0
            + longint'(kd) * (e0 - 2 * e1 + e2);
        if (acc <= 0)
          drive_level = '0;
        else if (acc < longint'(max_out))
          drive_level = DataW'(acc);
        else
          drive_level = max_out;
        due.branch = BR_CALC;
      end
      due.drive = drive_level;
      drive_due_q.push_back(due);
      samples++;
    endfunction

    function void check_drive(out_item_t got);
      out_item_t want;
      if (drive_due_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got drive %0d branch %0d",
                 $time, got.drive, got.branch);
        return;
      end
      want = drive_due_q.pop_front();
      checked++;
      if (got.drive !== want.drive) begin
        mismatches++;
        $display("%0t: drive mismatch, expected %0d, got %0d",
                 $time, want.drive, got.drive);
      end
      if (got.branch !== want.branch) begin
        mismatches++;
        $display("%0t: branch mismatch, expected %0d, got %0d",
                 $time, want.branch, got.branch);
      end
      if (want.branch <= BR_CALC) branch_count[want.branch]++;
    endfunction

    function int pending();
      return drive_due_q.size();
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [DataW-1:0]   cfg_data = '0;

  // Idling percentages, per cycle, for the sender and the receiver.
  int send_idle_pct = 0;
  int stall_pct = 0;
  int settings_applied = 0;
  int cycle_count = 0;

  heater_drive_tracker tracker;

  incremental_pid_heater_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // All handshakes are sampled at the rising edge, before any of this edge's
  // nonblocking updates land, so the values seen are the ones the block saw.
  // Register writes, accepted samples and results all go to the tracker in
  // the order in which the block takes them.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) tracker.note_sample(in_data);
      if (out_valid && !out_stall) tracker.check_drive(out_data);
    end
  end

  // The receiver stalls at random, at the rate the current phase asks for.
  always @(posedge clk) begin
    if (!rst_n)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // A hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still expected", $time, tracker.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one sample. The sender may idle first; once valid is up, it and
  // the payload hold until the block takes the item. Valid is left high on
  // return so that back-to-back items never lower and raise it in one step.
  task automatic send_sample(int sp, int ms);
    in_item_t s;
    s.setpoint = DataW'(sp);
    s.measured = DataW'(ms);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering items and waits for every expected result, then lets the
  // block drain anything still in flight inside it.
  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Holds one register write until the block takes it; valid stays up for
  // the next write and is lowered by the caller.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= DataW'(data);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes all five registers while the block is idle. Optionally it also
  // pokes the unused indexes, which the block must ignore.
  task automatic apply_settings(int kp, int ki, int kd, int mx, int bd, bit poke_unused);
    go_quiet();
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_MAX_OUTPUT, mx);
    write_reg(REG_BAND, bd);
    if (poke_unused) begin
      for (int idx = int'(REG_BAND) + 1; idx < (1 << CfgIdxW); idx++)
        write_reg(CfgIdxW'(idx), $urandom_range(0, FULL_SCALE));
    end
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  function automatic int pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return GAIN_TOP;
    if (r < 20) return 0;
    if (r < 35) return $urandom_range(0, GAIN_TOP);
    return $urandom_range(0, 6);
  endfunction

  // Random sample biased toward the computed path, where the history and the
  // stored drive matter; the rest turns the heater off or drives it full.
  task automatic random_sample(int bd);
    int r, err, cap, sp, ms;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      sp = $urandom_range(0, FULL_SCALE);
      ms = $urandom_range(sp, FULL_SCALE);
    end else begin
      if ((r < 30 && bd < FULL_SCALE) || bd == 0) begin
        err = $urandom_range(bd + 1, FULL_SCALE);
      end else begin
        cap = (r < 85 && bd > 64) ? 64 : bd;
        err = $urandom_range(1, cap);
      end
      ms = $urandom_range(0, FULL_SCALE - err);
      sp = ms + err;
    end
    send_sample(sp, ms);
  endtask

  initial begin
    int kp, ki, kd, mx, bd, r;
    tracker = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero gains, clamp 200, band 100. Equal inputs and a
    // measurement above the setpoint turn the heater off; a huge error
    // drives it full; an error equal to the band takes the computed path.
    send_sample(0, 0);
    send_sample(0, FULL_SCALE);
    send_sample(FULL_SCALE, 0);
    send_sample(100, 0);
    send_sample(1, 0);
    send_sample(FULL_SCALE, FULL_SCALE);

    // All gains and limits at their tops. A sharp drop in error gives a
    // negative increment, so the drive must fall to zero.
    apply_settings(GAIN_TOP, GAIN_TOP, GAIN_TOP, FULL_SCALE, FULL_SCALE, 1'b1);
    send_sample(FULL_SCALE, 0);
    send_sample(1, 0);
    send_sample(2, 0);
    send_sample('hAAAA, 'h5555);
    send_sample('h8000, 'h7FFF);

    // Full drive stores the top level; a lower clamp afterwards must cap the
    // stored drive on the next computed item.
    apply_settings(0, 0, 0, FULL_SCALE, 10, 1'b0);
    send_sample(FULL_SCALE, 0);
    apply_settings(0, 0, 0, 50, 10, 1'b0);
    send_sample(5, 0);
    send_sample(FULL_SCALE, 0);

    // A zero clamp: full drive and computed drive are both zero. With a zero
    // band every positive error goes to full drive.
    apply_settings(GAIN_TOP, GAIN_TOP, GAIN_TOP, 0, 0, 1'b0);
    send_sample(1, 0);
    send_sample(5, 5);
    apply_settings(GAIN_TOP, GAIN_TOP, GAIN_TOP, 0, FULL_SCALE, 1'b0);
    send_sample(FULL_SCALE, 0);
    send_sample(9, 3);

    // Random phases, each with its own settings and one of four idling patterns in
    // turn: none, a slow sender, a slow receiver, then both a little.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      kp = pick_gain();
      ki = pick_gain();
      kd = pick_gain();
      r = $urandom_range(0, 99);
      if (ph == 0 || r < 25)
        mx = FULL_SCALE;
      else if (r < 30)
        mx = 0;
      else
        mx = $urandom_range(1, FULL_SCALE);
      r = $urandom_range(0, 99);
      if (ph == 0 || r < 15)
        bd = FULL_SCALE;
      else if (r < 25)
        bd = 0;
      else if (r < 70)
        bd = $urandom_range(1, 400);
      else
        bd = $urandom_range(1, FULL_SCALE);
      apply_settings(kp, ki, kd, mx, bd, (ph % 3) == 0);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 52; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 52; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_sample(bd);
    end

    go_quiet();
    $display("Ran %0d samples under %0d register settings; %0d results checked.",
             tracker.samples, settings_applied, tracker.checked);
    $display("Results by branch: off %0d, full drive %0d, computed %0d; mismatches %0d.",
             tracker.branch_count[BR_OFF], tracker.branch_count[BR_FULL],
             tracker.branch_count[BR_CALC], tracker.mismatches);
    if (tracker.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
